// ----- hw/rtl/sbrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// sbrgb_pkg
// shared types, register codes, reset values and band routing for the
// spectrum band rgb mixer
// ----------------------------------------------------------------------------
package sbrgb_pkg;

  localparam int BINS_PER_FRAME_DEF = 512;

  localparam int MAG_W      = 16;
  localparam int PULSE_W    = 16;
  localparam int MODE_W     = 3;
  localparam int LEVEL_W    = 16;
  localparam int EDGE_LO_W  = 9;
  localparam int EDGE_W     = 10;
  localparam int TOTAL_W    = 18;
  localparam int PROD_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int BAND_W     = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BAND_ROUTE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LED_MAX      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_EDGE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_EDGE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THIRD_EDGE   = 3'd5;

  // register reset values
  localparam logic [MODE_W-1:0]    BAND_ROUTE_RST   = 3'd0;
  localparam logic [LEVEL_W-1:0]   CUTOFF_LEVEL_RST = 16'd7000;
  localparam logic [LEVEL_W-1:0]   LED_MAX_RST      = 16'd5000;
  localparam logic [EDGE_LO_W-1:0] FIRST_EDGE_RST   = 9'd18;
  localparam logic [EDGE_LO_W-1:0] SECOND_EDGE_RST  = 9'd45;
  localparam logic [EDGE_W-1:0]    THIRD_EDGE_RST   = 10'd140;

  // band indexes
  localparam logic [BAND_W-1:0] BAND_ONE   = 2'd0;
  localparam logic [BAND_W-1:0] BAND_TWO   = 2'd1;
  localparam logic [BAND_W-1:0] BAND_THREE = 2'd2;

  // colour routing codes, named red-green-blue by band
  localparam logic [MODE_W-1:0] MODE_R1_G2_B3 = 3'd0;
  localparam logic [MODE_W-1:0] MODE_R2_G3_B1 = 3'd1;
  localparam logic [MODE_W-1:0] MODE_R3_G1_B2 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_R2_G1_B3 = 3'd3;
  localparam logic [MODE_W-1:0] MODE_R1_G3_B2 = 3'd4;
  localparam logic [MODE_W-1:0] MODE_R3_G2_B1 = 3'd5;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             frame_end;
  } bin_item_t;

  typedef struct packed {
    logic [PULSE_W-1:0] red_pulse;
    logic [PULSE_W-1:0] green_pulse;
    logic [PULSE_W-1:0] blue_pulse;
  } led_item_t;

  typedef struct packed {
    logic              acc_en;
    logic              mul_en;
    logic              div_start;
    logic              pulse_wr;
    logic              pulse_zero;
    logic              out_load;
    logic [BAND_W-1:0] band_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic band_lit;
    logic div_busy;
    logic div_done;
    logic out_free;
  } dp_status_t;

  function automatic led_item_t route_bands(input logic [MODE_W-1:0]  mode,
                                            input logic [PULSE_W-1:0] p1,
                                            input logic [PULSE_W-1:0] p2,
                                            input logic [PULSE_W-1:0] p3);
    led_item_t r;
    case (mode)
      MODE_R2_G3_B1: r = '{red_pulse: p2, green_pulse: p3, blue_pulse: p1};
      MODE_R3_G1_B2: r = '{red_pulse: p3, green_pulse: p1, blue_pulse: p2};
      MODE_R2_G1_B3: r = '{red_pulse: p2, green_pulse: p1, blue_pulse: p3};
      MODE_R1_G3_B2: r = '{red_pulse: p1, green_pulse: p3, blue_pulse: p2};
      MODE_R3_G2_B1: r = '{red_pulse: p3, green_pulse: p2, blue_pulse: p1};
      default:       r = '{red_pulse: p1, green_pulse: p2, blue_pulse: p3};
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/spectrum_band_rgb_mixer.sv -----
// ----------------------------------------------------------------------------
// spectrum_band_rgb_mixer
// sums spectrum bins into three bands and turns each frame into rgb pulses
// ----------------------------------------------------------------------------
// bins are taken one per cycle until the item marked frame_end
// that item's result then reaches the output register via S_DONE after
// one S_SEL state per quiet band and S_SEL, S_START, S_WAIT per lit band (shared divider)
// the next frame's bins are stalled until the result is loaded
// rst is synchronous: clears control, config back to its reset values
// ----------------------------------------------------------------------------
module spectrum_band_rgb_mixer
  import sbrgb_pkg::*;
#(
  parameter int BINS_PER_FRAME = BINS_PER_FRAME_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // bin channel
  input  logic                  bin_valid,
  output logic                  bin_stall,
  input  bin_item_t             bin_data,
  // led channel
  output logic                  led_valid,
  input  logic                  led_stall,
  output led_item_t             led_data,
  // config write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // controller: bin intake, band sequencing, output hand-off
  sbrgb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .bin_valid (bin_valid),
    .frame_end (bin_data.frame_end),
    .sts       (sts),
    .cmd       (cmd),
    .bin_stall (bin_stall)
  );

  // datapath: accumulators, band product, divider, colour routing
  sbrgb_dp #(
    .BINS_PER_FRAME (BINS_PER_FRAME)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bin_data  (bin_data),
    .led_stall (led_stall),
    .cmd       (cmd),
    .sts       (sts),
    .led_valid (led_valid),
    .led_data  (led_data)
  );

  // a frame end item stops further bins until its result is out
  a_frame_end_stalls: assert property (@(posedge clk) disable iff (rst)
    (bin_valid && !bin_stall && bin_data.frame_end) |=> bin_stall)
    else $error("bin taken straight after frame end");

  // the divider is never restarted mid-division
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  // a quotient is stored only when the divider has finished
  a_pulse_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.pulse_wr |-> sts.div_done)
    else $error("pulse written without finished division");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!led_valid || !led_stall))
    else $error("output overwritten while stalled");

endmodule

// ----- hw/rtl/sbrgb_div.sv -----
// ----------------------------------------------------------------------------
// sbrgb_div
// restoring divider, one quotient bit a cycle; quotient known to fit 16 bits
// ----------------------------------------------------------------------------
module sbrgb_div
  import sbrgb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [PROD_W-1:0]  dividend,
  input  logic [TOTAL_W-1:0] divisor,
  output logic [PULSE_W-1:0] quotient,
  output logic               busy,
  output logic               done
);

  localparam int CNT_W = $clog2(PULSE_W);

  logic [TOTAL_W-1:0] rem;
  logic [PULSE_W-1:0] lo;
  logic [TOTAL_W-1:0] dvs;
  logic [CNT_W-1:0]   cnt;
  logic [TOTAL_W:0]   trial;
  logic               fits;

  assign trial    = {rem, lo[PULSE_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(PULSE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // upper half is below the divisor, so the quotient needs only the low half
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= TOTAL_W'(dividend[PROD_W-1:PULSE_W]);
      lo  <= dividend[PULSE_W-1:0];
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? TOTAL_W'(trial - {1'b0, dvs}) : trial[TOTAL_W-1:0];
      lo  <= {lo[PULSE_W-2:0], fits};
    end
  end

endmodule

// ----- hw/rtl/sbrgb_dp.sv -----
// ----------------------------------------------------------------------------
// sbrgb_dp
// datapath: config registers, band accumulators, multiplier, divider,
// pulse store and output register
// ----------------------------------------------------------------------------
module sbrgb_dp
  import sbrgb_pkg::*;
#(
  parameter int BINS_PER_FRAME = BINS_PER_FRAME_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  bin_item_t             bin_data,
  input  logic                  led_stall,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            sts,
  output logic                  led_valid,
  output led_item_t             led_data
);

  localparam int POS_W = $clog2(BINS_PER_FRAME + 1);
  localparam int CMP_W = (POS_W > EDGE_W) ? POS_W : EDGE_W;

  logic [MODE_W-1:0]    band_route;
  logic [LEVEL_W-1:0]   cutoff_level;
  logic [LEVEL_W-1:0]   led_max;
  logic [EDGE_LO_W-1:0] first_edge;
  logic [EDGE_LO_W-1:0] second_edge;
  logic [EDGE_W-1:0]    third_edge;

  logic [POS_W-1:0]   bin_position;
  logic [MAG_W-1:0]   band_one_sum;
  logic [MAG_W-1:0]   band_two_sum;
  logic [MAG_W-1:0]   band_three_sum;
  logic [PROD_W-1:0]  prod;
  logic [PULSE_W-1:0] pulse [3];

  logic [EDGE_W-1:0]  e1, e2, e3;
  logic [CMP_W-1:0]   pos_x;
  logic               in_frame;
  logic               in_one, in_two, in_three;
  logic [TOTAL_W-1:0] total;
  logic [MAG_W-1:0]   band_cur;
  logic [PULSE_W-1:0] quotient;
  logic               div_busy, div_done;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      band_route   <= BAND_ROUTE_RST;
      cutoff_level <= CUTOFF_LEVEL_RST;
      led_max      <= LED_MAX_RST;
      first_edge   <= FIRST_EDGE_RST;
      second_edge  <= SECOND_EDGE_RST;
      third_edge   <= THIRD_EDGE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BAND_ROUTE:   band_route   <= cfg_data[MODE_W-1:0];
        REG_CUTOFF_LEVEL: cutoff_level <= cfg_data[LEVEL_W-1:0];
        REG_LED_MAX:      led_max      <= cfg_data[LEVEL_W-1:0];
        REG_FIRST_EDGE:   first_edge   <= cfg_data[EDGE_LO_W-1:0];
        REG_SECOND_EDGE:  second_edge  <= cfg_data[EDGE_LO_W-1:0];
        REG_THIRD_EDGE:   third_edge   <= cfg_data[EDGE_W-1:0];
        default: ;
      endcase
    end
  end

  // edges forced into order
  always_comb begin
    e1 = (first_edge == '0) ? EDGE_W'(1) : EDGE_W'(first_edge);
    e2 = (EDGE_W'(second_edge) < e1) ? e1 : EDGE_W'(second_edge);
    e3 = (third_edge < e2) ? e2 : third_edge;
  end

  assign pos_x    = CMP_W'(bin_position);
  assign in_frame = bin_position < POS_W'(BINS_PER_FRAME);
  assign in_one   = (pos_x >= CMP_W'(1)) && (pos_x < CMP_W'(e1));
  assign in_two   = (pos_x >= CMP_W'(e1)) && (pos_x < CMP_W'(e2));
  assign in_three = (pos_x >= CMP_W'(e2)) && (pos_x < CMP_W'(e3));

  always_ff @(posedge clk) begin
    if (rst || cmd.out_load) begin
      bin_position   <= '0;
      band_one_sum   <= '0;
      band_two_sum   <= '0;
      band_three_sum <= '0;
    end else if (cmd.acc_en && in_frame) begin
      bin_position <= bin_position + 1'b1;
      if (in_one) begin
        band_one_sum <= band_one_sum + bin_data.magnitude;
      end else if (in_two) begin
        band_two_sum <= band_two_sum + bin_data.magnitude;
      end else if (in_three) begin
        band_three_sum <= band_three_sum + bin_data.magnitude;
      end
    end
  end

  assign total = TOTAL_W'(band_one_sum) + TOTAL_W'(band_two_sum)
               + TOTAL_W'(band_three_sum);

  always_comb begin
    case (cmd.band_sel)
      BAND_ONE: band_cur = band_one_sum;
      BAND_TWO: band_cur = band_two_sum;
      default:  band_cur = band_three_sum;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= band_cur * led_max;
    end
  end

  sbrgb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (total),
    .quotient (quotient),
    .busy     (div_busy),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.pulse_zero) begin
      pulse[cmd.band_sel] <= '0;
    end else if (cmd.pulse_wr) begin
      pulse[cmd.band_sel] <= quotient;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      led_valid <= 1'b0;
    end else if (cmd.out_load) begin
      led_valid <= 1'b1;
    end else if (!led_stall) begin
      led_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      led_data <= route_bands(band_route, pulse[0], pulse[1], pulse[2]);
    end
  end

  assign sts.band_lit = band_cur > cutoff_level;
  assign sts.div_busy = div_busy;
  assign sts.div_done = div_done;
  assign sts.out_free = !led_valid || !led_stall;

endmodule

// ----- hw/rtl/sbrgb_ctrl.sv -----
// ----------------------------------------------------------------------------
// sbrgb_ctrl
// frame controller: takes bins, then walks the three bands through the multiplier
// and, for a lit band, the divider, and hands the result to the output register
// ----------------------------------------------------------------------------
module sbrgb_ctrl
  import sbrgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       bin_valid,
  input  logic       frame_end,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd,
  output logic       bin_stall
);

  localparam logic [2:0] S_ACC   = 3'd0;
  localparam logic [2:0] S_SEL   = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state, state_next;
  logic [BAND_W-1:0] band, band_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
      band  <= BAND_ONE;
    end else begin
      state <= state_next;
      band  <= band_next;
    end
  end

  always_comb begin
    state_next = state;
    band_next  = band;
    cmd        = '0;
    cmd.band_sel = band;
    case (state)
      S_ACC: begin
        cmd.acc_en = bin_valid;
        if (bin_valid && frame_end) begin
          state_next = S_SEL;
          band_next  = BAND_ONE;
        end
      end
      S_SEL: begin
        cmd.mul_en = 1'b1;
        if (sts.band_lit) begin
          state_next = S_START;
        end else begin
          cmd.pulse_zero = 1'b1;
          if (band == BAND_THREE) begin
            state_next = S_DONE;
          end else begin
            band_next = band + 1'b1;
          end
        end
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (sts.div_done) begin
          cmd.pulse_wr = 1'b1;
          if (band == BAND_THREE) begin
            state_next = S_DONE;
          end else begin
            band_next  = band + 1'b1;
            state_next = S_SEL;
          end
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_ACC;
        end
      end
      default: begin
        state_next = S_ACC;
      end
    endcase
  end

  assign bin_stall = state != S_ACC;

endmodule
